>>> sv/cau_pkg.sv
// cau_pkg: command and status codes of the complex arithmetic unit
// no dependencies
`timescale 1ns / 1ps

package cau_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_ADD = 3'd0;
    localparam cmd_t CMD_SUB = 3'd1;
    localparam cmd_t CMD_MUL = 3'd2;
    localparam cmd_t CMD_DIV = 3'd3;
    localparam cmd_t CMD_MOD = 3'd4;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_DIV_ZERO = 2'd1;
    localparam status_t ST_SAT      = 2'd2;

endpackage

>>> sv/complex_arith_unit_core.sv
// complex_arith_unit_core: pipelined complex add, subtract, multiply, divide and modulus
// depends on cau_pkg (command and status codes)
`timescale 1ns / 1ps

// channel   signals                                  transfer
// input     start, busy, command, a_re..b_im          start high and busy low at clk edge
// result    done, res_re, res_im, status              done high for one cycle, always taken
//
// one item enters per cycle; busy is held low
// the pipeline has six front stages (magnitudes, split products,
// product sum, signs, cross terms, numerator magnitudes), one divide setup stage,
// DATA_WIDTH radix-2 divide and square root stages, one saturation stage
// reset clears the valid bits of all stages; the receiver cannot stall

module complex_arith_unit_core #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cau_pkg::cmd_t               command,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                        done,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output cau_pkg::status_t            status
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int H   = (W + 1) / 2;
    localparam int LH  = W - H;
    localparam int PW  = 2 * W;
    localparam int XW  = 2 * W + 2;
    localparam int RW  = 2 * W + 1;
    localparam int SW  = 2 * W + 2;
    localparam int NW  = RW + F;
    localparam int TW  = NW - W;
    localparam int CW  = (TW > RW) ? TW : RW;
    localparam int LAT = W + 8;

    localparam logic signed [XW-1:0] MAXP = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] MINN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic sat_flag(input logic signed [XW-1:0] x);
        return (x > MAXP) || (x < MINN);
    endfunction

    function automatic logic [W-1:0] sat_val(input logic signed [XW-1:0] x);
        logic [W-1:0] r;
        if (x > MAXP)
        begin
            r = MAXP[W-1:0];
        end
        else if (x < MINN)
        begin
            r = MINN[W-1:0];
        end
        else
        begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // stage 1: magnitudes, operand selection, add and subtract
    logic                  s1_v_reg;
    cau_pkg::cmd_t         s1_cmd_reg;
    logic [W-1:0]          s1_opx_reg [0:5];
    logic [W-1:0]          s1_opy_reg [0:5];
    logic [3:0]            s1_sgn_reg;
    logic signed [XW-1:0]  s1_ere_reg;
    logic signed [XW-1:0]  s1_eim_reg;

    logic [W-1:0]          m_ar, m_ai, m_br, m_bi;
    logic signed [XW-1:0]  x_ar, x_ai, x_br, x_bi;
    logic                  is_mod;

    always_comb
    begin
        m_ar   = mag_of(a_re);
        m_ai   = mag_of(a_im);
        m_br   = mag_of(b_re);
        m_bi   = mag_of(b_im);
        x_ar   = {{(XW-W){a_re[W-1]}}, a_re};
        x_ai   = {{(XW-W){a_im[W-1]}}, a_im};
        x_br   = {{(XW-W){b_re[W-1]}}, b_re};
        x_bi   = {{(XW-W){b_im[W-1]}}, b_im};
        is_mod = (command == cau_pkg::CMD_MOD);
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg    <= command;
        s1_opx_reg[0] <= m_ar;
        s1_opy_reg[0] <= m_br;
        s1_opx_reg[1] <= m_ai;
        s1_opy_reg[1] <= m_bi;
        s1_opx_reg[2] <= m_ai;
        s1_opy_reg[2] <= m_br;
        s1_opx_reg[3] <= m_ar;
        s1_opy_reg[3] <= m_bi;
        s1_opx_reg[4] <= is_mod ? m_ar : m_br;
        s1_opy_reg[4] <= is_mod ? m_ar : m_br;
        s1_opx_reg[5] <= is_mod ? m_ai : m_bi;
        s1_opy_reg[5] <= is_mod ? m_ai : m_bi;
        s1_sgn_reg    <= {a_re[W-1] ^ b_im[W-1], a_im[W-1] ^ b_re[W-1],
                          a_im[W-1] ^ b_im[W-1], a_re[W-1] ^ b_re[W-1]};
        case (command)
            cau_pkg::CMD_ADD:
            begin
                s1_ere_reg <= x_ar + x_br;
                s1_eim_reg <= x_ai + x_bi;
            end
            cau_pkg::CMD_SUB:
            begin
                s1_ere_reg <= x_ar - x_br;
                s1_eim_reg <= x_ai - x_bi;
            end
            default:
            begin
                s1_ere_reg <= '0;
                s1_eim_reg <= '0;
            end
        endcase
    end

    // stage 2: split partial products
    logic                  s2_v_reg;
    cau_pkg::cmd_t         s2_cmd_reg;
    logic [3:0]            s2_sgn_reg;
    logic signed [XW-1:0]  s2_ere_reg;
    logic signed [XW-1:0]  s2_eim_reg;
    logic [2*H-1:0]        s2_ll_reg [0:5];
    logic [W-1:0]          s2_lh_reg [0:5];
    logic [W-1:0]          s2_hl_reg [0:5];
    logic [2*LH-1:0]       s2_hh_reg [0:5];

    // stage 3: full unsigned products
    logic                  s3_v_reg;
    cau_pkg::cmd_t         s3_cmd_reg;
    logic [3:0]            s3_sgn_reg;
    logic signed [XW-1:0]  s3_ere_reg;
    logic signed [XW-1:0]  s3_eim_reg;
    logic [PW-1:0]         s3_p_reg [0:5];

    genvar j;
    generate
        for (j = 0; j < 6; j++)
        begin : g_mul
            always_ff @(posedge clk)
            begin
                s2_ll_reg[j] <= (2*H)'(s1_opx_reg[j][H-1:0]) * (2*H)'(s1_opy_reg[j][H-1:0]);
                s2_lh_reg[j] <= W'(s1_opx_reg[j][H-1:0]) * W'(s1_opy_reg[j][W-1:H]);
                s2_hl_reg[j] <= W'(s1_opx_reg[j][W-1:H]) * W'(s1_opy_reg[j][H-1:0]);
                s2_hh_reg[j] <= (2*LH)'(s1_opx_reg[j][W-1:H]) *
                                (2*LH)'(s1_opy_reg[j][W-1:H]);
                s3_p_reg[j]  <= (PW'(s2_hh_reg[j]) << (2*H))
                              + ((PW'(s2_lh_reg[j]) + PW'(s2_hl_reg[j])) << H)
                              + PW'(s2_ll_reg[j]);
            end
        end
    endgenerate

    // stage 4: signed cross products
    logic                  s4_v_reg;
    cau_pkg::cmd_t         s4_cmd_reg;
    logic signed [XW-1:0]  s4_ere_reg;
    logic signed [XW-1:0]  s4_eim_reg;
    logic signed [XW-1:0]  s4_s_reg [0:3];
    logic [PW-1:0]         s4_p4_reg;
    logic [PW-1:0]         s4_p5_reg;

    // stage 5: cross terms and squared magnitude
    logic                  s5_v_reg;
    cau_pkg::cmd_t         s5_cmd_reg;
    logic signed [XW-1:0]  s5_ere_reg;
    logic signed [XW-1:0]  s5_eim_reg;
    logic signed [XW-1:0]  s5_nr_reg;
    logic signed [XW-1:0]  s5_ni_reg;
    logic [RW-1:0]         s5_ds_reg;

    // stage 6: numerator magnitudes
    logic                  s6_v_reg;
    cau_pkg::cmd_t         s6_cmd_reg;
    logic signed [XW-1:0]  s6_ere_reg;
    logic signed [XW-1:0]  s6_eim_reg;
    logic [RW-1:0]         s6_nmr_reg;
    logic [RW-1:0]         s6_nmi_reg;
    logic                  s6_sr_reg;
    logic                  s6_si_reg;
    logic [RW-1:0]         s6_ds_reg;

    logic signed [XW-1:0]  mul_dre, mul_dim, neg_nr, neg_ni;

    always_comb
    begin
        mul_dre = s4_s_reg[0] - s4_s_reg[1];
        mul_dim = s4_s_reg[2] + s4_s_reg[3];
        neg_nr  = -s5_nr_reg;
        neg_ni  = -s5_ni_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg <= s1_cmd_reg;
        s2_sgn_reg <= s1_sgn_reg;
        s2_ere_reg <= s1_ere_reg;
        s2_eim_reg <= s1_eim_reg;

        s3_cmd_reg <= s2_cmd_reg;
        s3_sgn_reg <= s2_sgn_reg;
        s3_ere_reg <= s2_ere_reg;
        s3_eim_reg <= s2_eim_reg;

        s4_cmd_reg <= s3_cmd_reg;
        s4_ere_reg <= s3_ere_reg;
        s4_eim_reg <= s3_eim_reg;
        for (int k = 0; k < 4; k++)
        begin
            s4_s_reg[k] <= s3_sgn_reg[k] ? -$signed(XW'(s3_p_reg[k]))
                                         : $signed(XW'(s3_p_reg[k]));
        end
        s4_p4_reg <= s3_p_reg[4];
        s4_p5_reg <= s3_p_reg[5];

        s5_cmd_reg <= s4_cmd_reg;
        if (s4_cmd_reg == cau_pkg::CMD_MUL)
        begin
            s5_ere_reg <= mul_dre >>> F;
            s5_eim_reg <= mul_dim >>> F;
        end
        else
        begin
            s5_ere_reg <= s4_ere_reg;
            s5_eim_reg <= s4_eim_reg;
        end
        s5_nr_reg <= s4_s_reg[0] + s4_s_reg[1];
        s5_ni_reg <= s4_s_reg[2] - s4_s_reg[3];
        s5_ds_reg <= RW'(s4_p4_reg) + RW'(s4_p5_reg);

        s6_cmd_reg <= s5_cmd_reg;
        s6_ere_reg <= s5_ere_reg;
        s6_eim_reg <= s5_eim_reg;
        s6_sr_reg  <= s5_nr_reg[XW-1];
        s6_si_reg  <= s5_ni_reg[XW-1];
        s6_nmr_reg <= s5_nr_reg[XW-1] ? neg_nr[RW-1:0] : s5_nr_reg[RW-1:0];
        s6_nmi_reg <= s5_ni_reg[XW-1] ? neg_ni[RW-1:0] : s5_ni_reg[RW-1:0];
        s6_ds_reg  <= s5_ds_reg;
    end

    // divide and square root chain, one quotient and root bit per stage
    logic                  ch_v_reg    [0:W];
    cau_pkg::cmd_t         ch_cmd_reg  [0:W];
    logic signed [XW-1:0]  ch_ere_reg  [0:W];
    logic signed [XW-1:0]  ch_eim_reg  [0:W];
    logic                  ch_sr_reg   [0:W];
    logic                  ch_si_reg   [0:W];
    logic                  ch_ovr_reg  [0:W];
    logic                  ch_ovi_reg  [0:W];
    logic                  ch_zero_reg [0:W];
    logic [RW-1:0]         ch_d_reg    [0:W];
    logic [RW-1:0]         ch_rr_reg   [0:W];
    logic [RW-1:0]         ch_ri_reg   [0:W];
    logic [W-1:0]          ch_nr_reg   [0:W];
    logic [W-1:0]          ch_ni_reg   [0:W];
    logic [W-1:0]          ch_qr_reg   [0:W];
    logic [W-1:0]          ch_qi_reg   [0:W];
    logic [SW-1:0]         ch_rem_reg  [0:W];
    logic [W-1:0]          ch_root_reg [0:W];

    logic [NW-1:0]         nsh_r, nsh_i;
    logic [TW-1:0]         top_r, top_i;

    always_comb
    begin
        nsh_r = {s6_nmr_reg, {F{1'b0}}};
        nsh_i = {s6_nmi_reg, {F{1'b0}}};
        top_r = nsh_r[NW-1:W];
        top_i = nsh_i[NW-1:W];
    end

    always_ff @(posedge clk)
    begin
        ch_cmd_reg[0]  <= s6_cmd_reg;
        ch_ere_reg[0]  <= s6_ere_reg;
        ch_eim_reg[0]  <= s6_eim_reg;
        ch_sr_reg[0]   <= s6_sr_reg;
        ch_si_reg[0]   <= s6_si_reg;
        ch_ovr_reg[0]  <= CW'(top_r) >= CW'(s6_ds_reg);
        ch_ovi_reg[0]  <= CW'(top_i) >= CW'(s6_ds_reg);
        ch_zero_reg[0] <= (s6_ds_reg == '0);
        ch_d_reg[0]    <= s6_ds_reg;
        ch_rr_reg[0]   <= RW'(top_r);
        ch_ri_reg[0]   <= RW'(top_i);
        ch_nr_reg[0]   <= nsh_r[W-1:0];
        ch_ni_reg[0]   <= nsh_i[W-1:0];
        ch_qr_reg[0]   <= '0;
        ch_qi_reg[0]   <= '0;
        ch_rem_reg[0]  <= SW'(s6_ds_reg);
        ch_root_reg[0] <= '0;
    end

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_step
            localparam int B = W - 1 - k;
            logic [RW:0]   r2r, r2i;
            logic          ger, gei;
            logic [SW-1:0] trial;
            logic          ges;

            always_comb
            begin
                r2r   = {ch_rr_reg[k], ch_nr_reg[k][W-1]};
                r2i   = {ch_ri_reg[k], ch_ni_reg[k][W-1]};
                ger   = r2r >= {1'b0, ch_d_reg[k]};
                gei   = r2i >= {1'b0, ch_d_reg[k]};
                trial = (SW'(ch_root_reg[k]) << (B + 1)) | (SW'(1) << (2 * B));
                ges   = ch_rem_reg[k] >= trial;
            end

            always_ff @(posedge clk)
            begin
                ch_cmd_reg[k+1]  <= ch_cmd_reg[k];
                ch_ere_reg[k+1]  <= ch_ere_reg[k];
                ch_eim_reg[k+1]  <= ch_eim_reg[k];
                ch_sr_reg[k+1]   <= ch_sr_reg[k];
                ch_si_reg[k+1]   <= ch_si_reg[k];
                ch_ovr_reg[k+1]  <= ch_ovr_reg[k];
                ch_ovi_reg[k+1]  <= ch_ovi_reg[k];
                ch_zero_reg[k+1] <= ch_zero_reg[k];
                ch_d_reg[k+1]    <= ch_d_reg[k];
                ch_rr_reg[k+1]   <= ger ? RW'(r2r - {1'b0, ch_d_reg[k]}) : r2r[RW-1:0];
                ch_ri_reg[k+1]   <= gei ? RW'(r2i - {1'b0, ch_d_reg[k]}) : r2i[RW-1:0];
                ch_nr_reg[k+1]   <= ch_nr_reg[k] << 1;
                ch_ni_reg[k+1]   <= ch_ni_reg[k] << 1;
                ch_qr_reg[k+1]   <= {ch_qr_reg[k][W-2:0], ger};
                ch_qi_reg[k+1]   <= {ch_qi_reg[k][W-2:0], gei};
                ch_rem_reg[k+1]  <= ges ? (ch_rem_reg[k] - trial) : ch_rem_reg[k];
                ch_root_reg[k+1] <= ges ? (ch_root_reg[k] | (W'(1) << B)) : ch_root_reg[k];
            end
        end
    endgenerate

    // output stage: sign, selection, saturation
    logic                  done_reg;
    logic [W-1:0]          res_re_reg, res_im_reg;
    cau_pkg::status_t      status_reg;

    logic signed [XW-1:0]  qxr, qxi, vr, vi, xr, xi;
    cau_pkg::status_t      st_next;

    always_comb
    begin
        qxr = ch_ovr_reg[W] ? (XW'(1) << W) : XW'(ch_qr_reg[W]);
        qxi = ch_ovi_reg[W] ? (XW'(1) << W) : XW'(ch_qi_reg[W]);
        vr  = ch_sr_reg[W] ? -qxr : qxr;
        vi  = ch_si_reg[W] ? -qxi : qxi;
        case (ch_cmd_reg[W])
            cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_MUL:
            begin
                xr = ch_ere_reg[W];
                xi = ch_eim_reg[W];
            end
            cau_pkg::CMD_DIV:
            begin
                xr = ch_zero_reg[W] ? '0 : vr;
                xi = ch_zero_reg[W] ? '0 : vi;
            end
            cau_pkg::CMD_MOD:
            begin
                xr = {{(XW-W){1'b0}}, ch_root_reg[W]};
                xi = '0;
            end
            default:
            begin
                xr = '0;
                xi = '0;
            end
        endcase
        if (ch_cmd_reg[W] == cau_pkg::CMD_DIV && ch_zero_reg[W])
        begin
            st_next = cau_pkg::ST_DIV_ZERO;
        end
        else if (sat_flag(xr) || sat_flag(xi))
        begin
            st_next = cau_pkg::ST_SAT;
        end
        else
        begin
            st_next = cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= sat_val(xr);
        res_im_reg <= sat_val(xi);
        status_reg <= st_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            for (int n = 0; n <= W; n++)
            begin
                ch_v_reg[n] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg    <= start && !busy;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            s5_v_reg    <= s4_v_reg;
            s6_v_reg    <= s5_v_reg;
            ch_v_reg[0] <= s6_v_reg;
            for (int n = 0; n < W; n++)
            begin
                ch_v_reg[n+1] <= ch_v_reg[n];
            end
            done_reg <= ch_v_reg[W];
        end
    end

    assign done   = done_reg;
    assign res_re = res_re_reg;
    assign res_im = res_im_reg;
    assign status = status_reg;

    // fixed latency from transfer to result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing at fixed latency");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cau_pkg::ST_DIV_ZERO) |-> (res_re == '0 && res_im == '0))
        else $error("zero divisor result not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cau_pkg::ST_SAT) |->
        (res_re == MAXP[W-1:0] || res_re == MINN[W-1:0] ||
         res_im == MAXP[W-1:0] || res_im == MINN[W-1:0]))
        else $error("saturation flagged without a clipped part");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == cau_pkg::ST_OK || status == cau_pkg::ST_DIV_ZERO ||
                  status == cau_pkg::ST_SAT))
        else $error("unknown status code");

endmodule

>>> sim/cau_checker.sv
// cau_checker: watches the command and result channels of complex_arith_unit_core,
// predicts each result with wide integer arithmetic and compares; depends on cau_pkg
`timescale 1ns / 1ps

module cau_checker #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  cau_pkg::cmd_t                command,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    input  logic                         done,
    input  logic signed [DATA_WIDTH-1:0] res_re,
    input  logic signed [DATA_WIDTH-1:0] res_im,
    input  cau_pkg::status_t             status,
    output int                           errors,
    output int                           pending
);

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic signed [191:0]          acc_t;

    typedef struct {
        word_t            re;
        word_t            im;
        cau_pkg::status_t st;
    } cplx_result_t;

    cplx_result_t expected_q[$];

    function automatic word_t clip(input acc_t x, inout logic hit);
        acc_t hi_lim;
        acc_t lo_lim;
        hi_lim = (acc_t'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo_lim = -(acc_t'(1) <<< (DATA_WIDTH - 1));
        if (x > hi_lim)
        begin
            hit = 1'b1;
            return word_t'(hi_lim);
        end
        if (x < lo_lim)
        begin
            hit = 1'b1;
            return word_t'(lo_lim);
        end
        return word_t'(x);
    endfunction

    // signed quotient truncated toward zero, positive divisor
    function automatic acc_t quot_trunc(input acc_t n, input acc_t d);
        acc_t q;
        q = (n < 0) ? -n : n;
        q = q / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic acc_t int_sqrt(input acc_t s);
        acc_t r;
        acc_t t;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (acc_t'(1) <<< b);
            if (t * t <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic cplx_result_t complex_op(input cau_pkg::cmd_t c,
                                                input word_t ar, input word_t ai,
                                                input word_t br, input word_t bi);
        cplx_result_t o;
        acc_t xr, xi, yr, yi, re, im, d;
        logic hit;
        xr = ar; xi = ai; yr = br; yi = bi;
        re = 0; im = 0; hit = 1'b0;
        o.st = cau_pkg::ST_OK;
        case (c)
            cau_pkg::CMD_ADD:
            begin
                re = xr + yr;
                im = xi + yi;
            end
            cau_pkg::CMD_SUB:
            begin
                re = xr - yr;
                im = xi - yi;
            end
            cau_pkg::CMD_MUL:
            begin
                re = (xr * yr - xi * yi) >>> FRAC_BITS;
                im = (xi * yr + xr * yi) >>> FRAC_BITS;
            end
            cau_pkg::CMD_DIV:
            begin
                d = yr * yr + yi * yi;
                if (d == 0)
                    o.st = cau_pkg::ST_DIV_ZERO;
                else
                begin
                    re = quot_trunc((xr * yr + xi * yi) <<< FRAC_BITS, d);
                    im = quot_trunc((xi * yr - xr * yi) <<< FRAC_BITS, d);
                end
            end
            cau_pkg::CMD_MOD:
                re = int_sqrt(xr * xr + xi * xi);
            default: ;
        endcase
        o.re = clip(re, hit);
        o.im = clip(im, hit);
        if (hit && o.st == cau_pkg::ST_OK)
            o.st = cau_pkg::ST_SAT;
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        cplx_result_t e;
        if (!rst_n)
        begin
            errors <= 0;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result transfer with none expected: re %h im %h st %0d",
                             $time, res_re, res_im, status);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.re !== res_re || e.im !== res_im || e.st !== status)
                    begin
                        $display("%0t: mismatch expected re %h im %h st %0d, actual re %h im %h st %0d",
                                 $time, e.re, e.im, e.st, res_re, res_im, status);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(complex_op(command, a_re, a_im, b_re, b_im));
        end
    end

endmodule

>>> sim/tb_top.sv
// tb_top: stimulus and verdict for complex_arith_unit_core
// depends on cau_pkg, complex_arith_unit_core and cau_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int LATENCY    = DATA_WIDTH + 8;
    localparam int RAND_ITEMS = 1330;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cau_pkg::cmd_t    command;
    word_t            a_re, a_im, b_re, b_im;
    logic             done;
    word_t            res_re, res_im;
    cau_pkg::status_t status;
    int               errors;
    int               pending;
    int               cycles = 0;
    int               idle_pct;

    complex_arith_unit_core #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) dut (.*);

    cau_checker #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic word_t rand_word();
        case ($urandom_range(0, 7))
            0: return word_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
            1: return word_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
            2: return word_t'(0);
            3: return word_t'($urandom_range(0, 1) ? 32'sh10000 : -32'sh10000);
            4, 5: return word_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
            default: return word_t'($urandom);
        endcase
    endfunction

    // one transfer; the sender may idle first
    task automatic send(input cau_pkg::cmd_t c, input word_t ar, input word_t ai,
                        input word_t br, input word_t bi);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= c;
        a_re    <= ar;
        a_im    <= ai;
        b_re    <= br;
        b_im    <= bi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic random_phase(input int pct, input int n);
        cau_pkg::cmd_t c;
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            c = ($urandom_range(0, 19) == 0) ? cau_pkg::cmd_t'($urandom_range(5, 7))
                                              : cau_pkg::cmd_t'($urandom_range(0, 4));
            if (c == cau_pkg::CMD_DIV && $urandom_range(0, 14) == 0)
                send(c, rand_word(), rand_word(), '0, '0);
            else
                send(c, rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    initial
    begin
        word_t max_w, min_w;
        max_w = word_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
        min_w = word_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
        idle_pct = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        command  = cau_pkg::CMD_ADD;
        a_re = '0; a_im = '0; b_re = '0; b_im = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(cau_pkg::CMD_ADD, max_w, min_w, max_w, min_w);
        send(cau_pkg::CMD_ADD, 32'sh10000, -32'sh8000, 32'sh20000, 32'sh1);
        send(cau_pkg::CMD_SUB, min_w, max_w, max_w, min_w);
        send(cau_pkg::CMD_SUB, 32'sh30000, 32'sh0, 32'sh10000, -32'sh10000);
        send(cau_pkg::CMD_MUL, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh8000);
        send(cau_pkg::CMD_MUL, max_w, max_w, max_w, min_w);
        send(cau_pkg::CMD_MUL, min_w, min_w, min_w, min_w);
        send(cau_pkg::CMD_MUL, -32'sh1, 32'sh0, 32'sh1, 32'sh0);
        send(cau_pkg::CMD_DIV, 32'sh10000, 32'sh0, 32'sh0, 32'sh0);
        send(cau_pkg::CMD_DIV, max_w, min_w, 32'sh0, 32'sh0);
        send(cau_pkg::CMD_DIV, 32'sh10000, 32'sh10000, 32'sh20000, -32'sh10000);
        send(cau_pkg::CMD_DIV, max_w, max_w, 32'sh1, 32'sh0);
        send(cau_pkg::CMD_DIV, min_w, min_w, min_w, min_w);
        send(cau_pkg::CMD_DIV, -32'sh7, 32'sh3, 32'sh1, 32'sh1);
        send(cau_pkg::CMD_MOD, 32'sh30000, 32'sh40000, 32'sh0, 32'sh0);
        send(cau_pkg::CMD_MOD, max_w, max_w, 32'sh0, 32'sh0);
        send(cau_pkg::CMD_MOD, min_w, 32'sh0, 32'sh0, 32'sh0);
        send(cau_pkg::CMD_MOD, -32'sh3, 32'sh0, max_w, min_w);
        send(cau_pkg::cmd_t'(5), max_w, min_w, 32'sh5, 32'sh5);
        send(cau_pkg::cmd_t'(6), 32'sh1, 32'sh1, 32'sh1, 32'sh1);
        send(cau_pkg::cmd_t'(7), min_w, max_w, min_w, max_w);

        random_phase(18, RAND_ITEMS / 3);
        random_phase(57, RAND_ITEMS / 3);
        random_phase(0, RAND_ITEMS / 3);
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> complex_arith_unit_core.f
sv/cau_pkg.sv
sv/complex_arith_unit_core.sv
sim/cau_checker.sv
sim/tb_top.sv
